// ----- hw/rtl/sud_pkg.sv -----
// ---------------------------------------------------------------------------
// sud_pkg
// Shared types and operation codes for the 32-bit shift-subtract divider.
// ---------------------------------------------------------------------------
package sud_pkg;

  localparam int unsigned DataW = 32;

  // Operation codes carried on the action input
  localparam logic [1:0] ACT_UQUO = 2'd0;
  localparam logic [1:0] ACT_UREM = 2'd1;
  localparam logic [1:0] ACT_SQUO = 2'd2;
  localparam logic [1:0] ACT_SREM = 2'd3;

  // Request from the sign stage to the divide core
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
  } sud_req_t;

  // Response from the divide core
  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] rem;
  } sud_rsp_t;

endpackage

// ----- hw/rtl/signed_unsigned_divider_32_top.sv -----
// ---------------------------------------------------------------------------
// signed_unsigned_divider_32_top
// 32-bit signed/unsigned divider returning a quotient or a remainder.
// ---------------------------------------------------------------------------
// Usage:
//   An item (action_i, dividend_i, divisor_i) is taken at a rising edge with
//   start high and busy low. busy stays high until the result is issued.
//   The result appears on result_o for exactly one cycle with valid_o high;
//   the receiver cannot stall, so it must take the item in that cycle.
//   Signed operations divide magnitudes; the quotient takes the XOR of the
//   operand signs, the remainder the dividend's sign, all modulo 2^32.
//   A zero divisor gives quotient 0 and remainder equal to the dividend.
// Sequencing:
//   After acceptance the core shifts the divisor left once per alignment
//   step (0 to 31 shifts), then runs one single-bit restoring subtract step
//   per quotient bit; its done flag and valid_o are registered. A zero
//   divisor skips both phases. One item is in flight at a time, and a new
//   item may be started in the cycle its predecessor's result is shown.
// Reset:
//   rst_ni clears busy and valid; any item in flight is dropped.
// ---------------------------------------------------------------------------
module signed_unsigned_divider_32_top import sud_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             valid_o,
  output logic [DataW-1:0] result_o
);

  logic             accept;
  logic             is_signed;
  logic             want_rem;
  logic             num_neg, den_neg;
  logic             busy_q, busy_d;
  logic             valid_q, valid_d;
  logic             rem_q;
  logic             neg_q;
  logic [DataW-1:0] result_q, result_d;
  logic [DataW-1:0] sel_res;
  sud_req_t         req;
  sud_rsp_t         rsp;

  assign accept    = start && !busy_q;
  assign is_signed = (action_i == ACT_SQUO) || (action_i == ACT_SREM);
  assign want_rem  = (action_i == ACT_UREM) || (action_i == ACT_SREM);
  assign num_neg   = is_signed && dividend_i[DataW-1];
  assign den_neg   = is_signed && divisor_i[DataW-1];

  // Reduce operands to magnitudes on acceptance
  always_comb begin
    req.start = accept;
    req.num   = num_neg ? (DataW'(0) - dividend_i) : dividend_i;
    req.den   = den_neg ? (DataW'(0) - divisor_i) : divisor_i;
  end

  sud_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Pick and sign-correct the core's answer
  assign sel_res  = rem_q ? rsp.rem : rsp.quo;
  assign result_d = neg_q ? (DataW'(0) - sel_res) : sel_res;

  always_comb begin
    busy_d  = busy_q;
    valid_d = 1'b0;
    if (accept) begin
      busy_d = 1'b1;
    end else if (rsp.done) begin
      busy_d  = 1'b0;
      valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  // Hold the operation flags for the item in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rem_q <= want_rem;
      neg_q <= want_rem ? num_neg : (num_neg ^ den_neg);
    end
    if (rsp.done) begin
      result_q <= result_d;
    end
  end

  assign busy     = busy_q;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  // Checks
  a_valid_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result issued while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_done_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> busy_q) else $error("core finished with no item in flight");

endmodule

// ----- hw/rtl/sud_core.sv -----
// ---------------------------------------------------------------------------
// sud_core
// Unsigned restoring divider: aligns the divisor left one place a cycle,
// then retires one quotient bit a cycle through shift registers.
// ---------------------------------------------------------------------------
module sud_core import sud_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sud_req_t req_i,
  output sud_rsp_t rsp_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALIGN = 2'd1;
  localparam logic [1:0] S_SUB   = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             done_q, done_d;
  logic [DataW-1:0] num_q, num_d;
  logic [DataW-1:0] den_q, den_d;
  logic [DataW-1:0] bit_q, bit_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW:0]   diff;

  assign diff = {1'b0, num_q} - {1'b0, den_q};

  // Sequence alignment and subtract steps
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    num_d   = num_q;
    den_d   = den_q;
    bit_d   = bit_q;
    quo_d   = quo_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          num_d = req_i.num;
          den_d = req_i.den;
          bit_d = {{(DataW-1){1'b0}}, 1'b1};
          quo_d = '0;
          if (req_i.den == '0) begin
            // Zero divisor: quotient stays zero, remainder is the dividend
            done_d = 1'b1;
          end else begin
            state_d = S_ALIGN;
          end
        end
      end
      S_ALIGN: begin
        if ((den_q < num_q) && !den_q[DataW-1]) begin
          den_d = {den_q[DataW-2:0], 1'b0};
          bit_d = {bit_q[DataW-2:0], 1'b0};
        end else begin
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        if (!diff[DataW]) begin
          num_d = diff[DataW-1:0];
          quo_d = quo_q | bit_q;
        end
        bit_d = {1'b0, bit_q[DataW-1:1]};
        den_d = {1'b0, den_q[DataW-1:1]};
        if (bit_q[0]) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    bit_q <= bit_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = num_q;

endmodule
